### src/qes_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic equation solver package
// Widths, result codes and pipeline sideband types shared by the solver.
// ----------------------------------------------------------------------------
package qes_pkg;

  localparam int CW   = 32;          // coefficient and root width
  localparam int FB   = 16;          // fraction bits
  localparam int TW   = 16;          // tolerance register width
  localparam int PW   = 2 * CW;      // product width
  localparam int DW   = 2 * CW + 2;  // discriminant width, even for the square root
  localparam int RW   = DW / 2;      // square root width
  localparam int NW   = CW + 3;      // signed numerator width
  localparam int QW   = CW + 2 + FB; // dividend and quotient width
  localparam int EW   = CW + 1;      // divisor width
  localparam int REMW = RW + 2;      // square root remainder width

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2,
    CNT_INF  = 2'd3
  } cnt_t;

  typedef struct packed {
    logic          lin;
    logic          use_div;
    cnt_t          cnt;
    logic          a_neg;
    logic          b_neg;
    logic [CW-1:0] mag_a;
    logic [CW-1:0] mag_b;
    logic [CW-1:0] coef_b;
    logic [CW-1:0] coef_c;
  } sq_sb_t;

  typedef struct packed {
    logic lin;
    logic use_div;
    cnt_t cnt;
    logic neg_lo;
    logic neg_hi;
  } div_sb_t;

endpackage

### src/qes_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, restoring digit-by-digit method, floor result.
// ----------------------------------------------------------------------------
module qes_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [qes_pkg::DW-1:0]     in_rad,
  input  qes_pkg::sq_sb_t            in_sb,
  output logic                       out_vld,
  output logic [qes_pkg::RW-1:0]     out_root,
  output qes_pkg::sq_sb_t            out_sb
);

  logic                        vld_r  [qes_pkg::RW];
  logic [qes_pkg::REMW-1:0]    rem_r  [qes_pkg::RW];
  logic [qes_pkg::RW-1:0]      root_r [qes_pkg::RW];
  logic [qes_pkg::DW-1:0]      rad_r  [qes_pkg::RW];
  qes_pkg::sq_sb_t             sb_r   [qes_pkg::RW];

  genvar k;
  for (k = 0; k < qes_pkg::RW; k++) begin : g_stage
    logic                     vld_i;
    logic [qes_pkg::REMW-1:0] rem_i;
    logic [qes_pkg::RW-1:0]   root_i;
    logic [qes_pkg::DW-1:0]   rad_i;
    qes_pkg::sq_sb_t          sb_i;
    logic [qes_pkg::REMW-1:0] rem_sh;
    logic [qes_pkg::REMW-1:0] trial;
    logic                     ge;
    logic [qes_pkg::REMW-1:0] rem_nxt;
    logic [qes_pkg::RW-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign vld_i  = in_vld;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = in_rad;
      assign sb_i   = in_sb;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign sb_i   = sb_r[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    always_comb begin
      rem_sh   = {rem_i[qes_pkg::REMW-3:0], rad_i[qes_pkg::DW-1:qes_pkg::DW-2]};
      trial    = {root_i, 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_i[qes_pkg::RW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        rad_r[k]  <= {rad_i[qes_pkg::DW-3:0], 2'b00};
        sb_r[k]   <= sb_i;
      end
    end
  end

  assign out_vld  = vld_r[qes_pkg::RW-1];
  assign out_root = root_r[qes_pkg::RW-1];
  assign out_sb   = sb_r[qes_pkg::RW-1];

endmodule

### src/qes_div.sv
// ----------------------------------------------------------------------------
// Pipelined dual divider
// Two restoring dividers sharing one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qes_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [qes_pkg::QW-1:0] in_num_lo,
  input  logic [qes_pkg::QW-1:0] in_num_hi,
  input  logic [qes_pkg::EW-1:0] in_den,
  input  qes_pkg::div_sb_t       in_sb,
  output logic                   out_vld,
  output logic [qes_pkg::QW-1:0] out_q_lo,
  output logic [qes_pkg::QW-1:0] out_q_hi,
  output qes_pkg::div_sb_t       out_sb
);

  logic                   vld_r    [qes_pkg::QW];
  logic [qes_pkg::QW-1:0] nlo_r    [qes_pkg::QW];
  logic [qes_pkg::QW-1:0] nhi_r    [qes_pkg::QW];
  logic [qes_pkg::EW-1:0] remlo_r  [qes_pkg::QW];
  logic [qes_pkg::EW-1:0] remhi_r  [qes_pkg::QW];
  logic [qes_pkg::QW-1:0] qlo_r    [qes_pkg::QW];
  logic [qes_pkg::QW-1:0] qhi_r    [qes_pkg::QW];
  logic [qes_pkg::EW-1:0] den_r    [qes_pkg::QW];
  qes_pkg::div_sb_t       sb_r     [qes_pkg::QW];

  genvar k;
  for (k = 0; k < qes_pkg::QW; k++) begin : g_stage
    logic                   vld_i;
    logic [qes_pkg::QW-1:0] nlo_i, nhi_i, qlo_i, qhi_i;
    logic [qes_pkg::EW-1:0] remlo_i, remhi_i, den_i;
    qes_pkg::div_sb_t       sb_i;
    logic [qes_pkg::EW:0]   shlo, shhi, dfl, dfh;
    logic                   gelo, gehi;

    if (k == 0) begin : g_first
      assign vld_i   = in_vld;
      assign nlo_i   = in_num_lo;
      assign nhi_i   = in_num_hi;
      assign remlo_i = '0;
      assign remhi_i = '0;
      assign qlo_i   = '0;
      assign qhi_i   = '0;
      assign den_i   = in_den;
      assign sb_i    = in_sb;
    end else begin : g_next
      assign vld_i   = vld_r[k-1];
      assign nlo_i   = nlo_r[k-1];
      assign nhi_i   = nhi_r[k-1];
      assign remlo_i = remlo_r[k-1];
      assign remhi_i = remhi_r[k-1];
      assign qlo_i   = qlo_r[k-1];
      assign qhi_i   = qhi_r[k-1];
      assign den_i   = den_r[k-1];
      assign sb_i    = sb_r[k-1];
    end

    always_comb begin
      shlo = {remlo_i, nlo_i[qes_pkg::QW-1]};
      shhi = {remhi_i, nhi_i[qes_pkg::QW-1]};
      gelo = (shlo >= {1'b0, den_i});
      gehi = (shhi >= {1'b0, den_i});
      dfl  = gelo ? (shlo - {1'b0, den_i}) : shlo;
      dfh  = gehi ? (shhi - {1'b0, den_i}) : shhi;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nlo_r[k]   <= {nlo_i[qes_pkg::QW-2:0], 1'b0};
        nhi_r[k]   <= {nhi_i[qes_pkg::QW-2:0], 1'b0};
        remlo_r[k] <= dfl[qes_pkg::EW-1:0];
        remhi_r[k] <= dfh[qes_pkg::EW-1:0];
        qlo_r[k]   <= {qlo_i[qes_pkg::QW-2:0], gelo};
        qhi_r[k]   <= {qhi_i[qes_pkg::QW-2:0], gehi};
        den_r[k]   <= den_i;
        sb_r[k]    <= sb_i;
      end
    end
  end

  assign out_vld  = vld_r[qes_pkg::QW-1];
  assign out_q_lo = qlo_r[qes_pkg::QW-1];
  assign out_q_hi = qhi_r[qes_pkg::QW-1];
  assign out_sb   = sb_r[qes_pkg::QW-1];

endmodule

### src/quadratic_equation_solver_top.sv
// Pipeline: 3 front stages, 33 square root stages, 1 numerator stage, 50 divider
// stages and 1 output register between input transfer and result.
// Throughput: one equation per cycle; the whole pipeline holds while a
// finished result waits at the output and out_ready is low.
// Reset: synchronous, active low; clears all valid bits and sets the zero
// tolerance to 0.
// ----------------------------------------------------------------------------
// Quadratic equation solver
// Real roots of a*x^2+b*x+c=0 in signed Q16.16, with linear fallback.
// ----------------------------------------------------------------------------
module quadratic_equation_solver_top (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [qes_pkg::TW-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [qes_pkg::CW-1:0] in_coeff_a,
  input  logic [qes_pkg::CW-1:0] in_coeff_b,
  input  logic [qes_pkg::CW-1:0] in_coeff_c,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             out_root_count,
  output logic [qes_pkg::CW-1:0] out_root_low,
  output logic [qes_pkg::CW-1:0] out_root_high,
  output logic                   out_overflow
);

  localparam int CW = qes_pkg::CW;

  logic                   en;
  logic [qes_pkg::TW-1:0] tol_r;

  // Stage 1: magnitudes and zero tests.
  logic          v1_r;
  logic          an1_r, bn1_r, cn1_r, az1_r, bz1_r, cz1_r;
  logic [CW-1:0] ma1_r, mb1_r, mc1_r, b1_r, c1_r;
  logic [CW-1:0] ma_nxt, mb_nxt, mc_nxt, tol_ext;

  // Stage 2: products.
  logic                   v2_r;
  logic                   an2_r, bn2_r, cn2_r, az2_r, bz2_r, cz2_r;
  logic [CW-1:0]          ma2_r, mb2_r, b2_r, c2_r;
  logic [qes_pkg::PW-1:0] bb2_r, ac2_r, bb_nxt, ac_nxt;

  // Stage 3: discriminant and case selection.
  logic                   v3_r;
  logic [qes_pkg::DW-1:0] d3_r, d_nxt, ac4, bbx;
  qes_pkg::sq_sb_t        sb3_r, sb3_nxt;

  // Square root output.
  logic                   sq_vld;
  logic [qes_pkg::RW-1:0] sq_root;
  qes_pkg::sq_sb_t        sq_sb;

  // Stage 4: numerators and divisor.
  logic                   v4_r;
  logic [qes_pkg::QW-1:0] nlo4_r, nhi4_r;
  logic [qes_pkg::EW-1:0] den4_r;
  qes_pkg::div_sb_t       sb4_r, sb4_nxt;
  logic [qes_pkg::NW-1:0] b_ext, c_ext, s_ext, num_lo, num_hi, abs_lo, abs_hi;
  logic [qes_pkg::EW-1:0] den_nxt;
  logic                   den_neg;

  // Divider output.
  logic                   dv_vld;
  logic [qes_pkg::QW-1:0] q_lo, q_hi;
  qes_pkg::div_sb_t       dv_sb;

  // Output register.
  logic          out_valid_r, ovf_r;
  qes_pkg::cnt_t cnt_r;
  logic [CW-1:0] rlo_r, rhi_r, rlo_nxt, rhi_nxt;
  logic          ovf_lo, ovf_hi;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_valid) begin
      tol_r <= cfg_data;
    end
  end

  // ---------------- Stage 1 ----------------
  always_comb begin
    ma_nxt  = in_coeff_a[CW-1] ? (~in_coeff_a + 1'b1) : in_coeff_a;
    mb_nxt  = in_coeff_b[CW-1] ? (~in_coeff_b + 1'b1) : in_coeff_b;
    mc_nxt  = in_coeff_c[CW-1] ? (~in_coeff_c + 1'b1) : in_coeff_c;
    tol_ext = {{(CW-qes_pkg::TW){1'b0}}, tol_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an1_r <= in_coeff_a[CW-1];
      bn1_r <= in_coeff_b[CW-1];
      cn1_r <= in_coeff_c[CW-1];
      az1_r <= (ma_nxt <= tol_ext);
      bz1_r <= (mb_nxt <= tol_ext);
      cz1_r <= (mc_nxt <= tol_ext);
      ma1_r <= ma_nxt;
      mb1_r <= mb_nxt;
      mc1_r <= mc_nxt;
      b1_r  <= in_coeff_b;
      c1_r  <= in_coeff_c;
    end
  end

  // ---------------- Stage 2 ----------------
  always_comb begin
    bb_nxt = {{CW{1'b0}}, mb1_r} * {{CW{1'b0}}, mb1_r};
    ac_nxt = {{CW{1'b0}}, ma1_r} * {{CW{1'b0}}, mc1_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an2_r <= an1_r;
      bn2_r <= bn1_r;
      cn2_r <= cn1_r;
      az2_r <= az1_r;
      bz2_r <= bz1_r;
      cz2_r <= cz1_r;
      ma2_r <= ma1_r;
      mb2_r <= mb1_r;
      b2_r  <= b1_r;
      c2_r  <= c1_r;
      bb2_r <= bb_nxt;
      ac2_r <= ac_nxt;
    end
  end

  // ---------------- Stage 3 ----------------
  always_comb begin
    ac4            = {ac2_r, 2'b00};
    bbx            = {2'b00, bb2_r};
    d_nxt          = '0;
    sb3_nxt.lin    = 1'b0;
    sb3_nxt.use_div = 1'b0;
    sb3_nxt.cnt    = qes_pkg::CNT_NONE;
    sb3_nxt.a_neg  = an2_r;
    sb3_nxt.b_neg  = bn2_r;
    sb3_nxt.mag_a  = ma2_r;
    sb3_nxt.mag_b  = mb2_r;
    sb3_nxt.coef_b = b2_r;
    sb3_nxt.coef_c = c2_r;
    if (az2_r) begin
      if (bz2_r) begin
        sb3_nxt.cnt = cz2_r ? qes_pkg::CNT_INF : qes_pkg::CNT_NONE;
      end else begin
        sb3_nxt.cnt     = qes_pkg::CNT_ONE;
        sb3_nxt.lin     = 1'b1;
        sb3_nxt.use_div = 1'b1;
      end
    end else if (an2_r != cn2_r) begin
      d_nxt           = bbx + ac4;
      sb3_nxt.cnt     = qes_pkg::CNT_TWO;
      sb3_nxt.use_div = 1'b1;
    end else if (ac4 <= bbx) begin
      d_nxt           = bbx - ac4;
      sb3_nxt.cnt     = qes_pkg::CNT_TWO;
      sb3_nxt.use_div = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_r  <= d_nxt;
      sb3_r <= sb3_nxt;
    end
  end

  qes_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v3_r),
    .in_rad   (d3_r),
    .in_sb    (sb3_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_sb   (sq_sb)
  );

  // ---------------- Stage 4 ----------------
  // The linear case divides -c by b; the quadratic case divides -b -+ sqrt(D) by 2a.
  always_comb begin
    b_ext = {{(qes_pkg::NW-CW){sq_sb.coef_b[CW-1]}}, sq_sb.coef_b};
    c_ext = {{(qes_pkg::NW-CW){sq_sb.coef_c[CW-1]}}, sq_sb.coef_c};
    s_ext = {{(qes_pkg::NW-qes_pkg::RW){1'b0}}, sq_root};
    if (sq_sb.lin) begin
      num_lo  = -c_ext;
      num_hi  = -c_ext;
      den_nxt = {1'b0, sq_sb.mag_b};
      den_neg = sq_sb.b_neg;
    end else begin
      num_lo  = -b_ext - s_ext;
      num_hi  = -b_ext + s_ext;
      den_nxt = {sq_sb.mag_a, 1'b0};
      den_neg = sq_sb.a_neg;
    end
    abs_lo          = num_lo[qes_pkg::NW-1] ? -num_lo : num_lo;
    abs_hi          = num_hi[qes_pkg::NW-1] ? -num_hi : num_hi;
    sb4_nxt.lin     = sq_sb.lin;
    sb4_nxt.use_div = sq_sb.use_div;
    sb4_nxt.cnt     = sq_sb.cnt;
    sb4_nxt.neg_lo  = num_lo[qes_pkg::NW-1] != den_neg;
    sb4_nxt.neg_hi  = num_hi[qes_pkg::NW-1] != den_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nlo4_r <= {abs_lo[qes_pkg::NW-2:0], {qes_pkg::FB{1'b0}}};
      nhi4_r <= {abs_hi[qes_pkg::NW-2:0], {qes_pkg::FB{1'b0}}};
      den4_r <= den_nxt;
      sb4_r  <= sb4_nxt;
    end
  end

  qes_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (v4_r),
    .in_num_lo (nlo4_r),
    .in_num_hi (nhi4_r),
    .in_den    (den4_r),
    .in_sb     (sb4_r),
    .out_vld   (dv_vld),
    .out_q_lo  (q_lo),
    .out_q_hi  (q_hi),
    .out_sb    (dv_sb)
  );

  // ---------------- Output ----------------
  function automatic logic [CW:0] sat_root(input logic [qes_pkg::QW-1:0] q,
                                           input logic neg);
    logic [CW-1:0] lim;
    logic          ovf;
    logic [CW-1:0] m;
    lim = neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    ovf = q > {{(qes_pkg::QW-CW){1'b0}}, lim};
    m   = ovf ? lim : q[CW-1:0];
    return {ovf, neg ? (~m + 1'b1) : m};
  endfunction

  always_comb begin
    {ovf_lo, rlo_nxt} = sat_root(q_lo, dv_sb.neg_lo);
    {ovf_hi, rhi_nxt} = sat_root(q_hi, dv_sb.neg_hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r <= dv_sb.cnt;
      if (!dv_sb.use_div) begin
        rlo_r <= '0;
        rhi_r <= '0;
        ovf_r <= 1'b0;
      end else if (dv_sb.lin) begin
        rlo_r <= rlo_nxt;
        rhi_r <= rlo_nxt;
        ovf_r <= ovf_lo;
      end else begin
        rlo_r <= rlo_nxt;
        rhi_r <= rhi_nxt;
        ovf_r <= ovf_lo | ovf_hi;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_root_count = cnt_r;
  assign out_root_low   = rlo_r;
  assign out_root_high  = rhi_r;
  assign out_overflow   = ovf_r;

endmodule

### test/quadratic_equation_solver_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadratic equation solver checker
// Watches the configuration, equation and result channels, computes the
// expected roots of every accepted equation and compares each result field by
// field, in order, against them.
// ----------------------------------------------------------------------------
module quadratic_equation_solver_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [qes_pkg::TW-1:0] cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [qes_pkg::CW-1:0] in_coeff_a,
  input  logic [qes_pkg::CW-1:0] in_coeff_b,
  input  logic [qes_pkg::CW-1:0] in_coeff_c,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             out_root_count,
  input  logic [qes_pkg::CW-1:0] out_root_low,
  input  logic [qes_pkg::CW-1:0] out_root_high,
  input  logic                   out_overflow,
  output int                     roots_pending,
  output int                     error_count
);

  typedef struct packed {
    qes_pkg::cnt_t          cnt;
    logic [qes_pkg::CW-1:0] lo;
    logic [qes_pkg::CW-1:0] hi;
    logic                   ovf;
  } roots_t;

  logic [qes_pkg::TW-1:0] tolerance;
  roots_t                 expected_roots[$];
  int                     errors;

  // Quotient num * 2^FB / (+-den), truncated toward zero and saturated.
  function automatic logic [qes_pkg::CW-1:0] scaled_quotient(
      input logic signed [63:0] num, input logic [63:0] den, input logic den_neg,
      inout logic ovf);
    logic         neg;
    logic [63:0]  num_mag;
    logic [127:0] dividend;
    logic [127:0] quot;
    logic [127:0] lim;
    neg      = (num < 0) != den_neg;
    num_mag  = (num < 0) ? -num : num;
    dividend = {64'd0, num_mag} << qes_pkg::FB;
    quot     = dividend / {64'd0, den};
    lim      = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (quot > lim) begin
      ovf  = 1'b1;
      quot = lim;
    end
    return neg ? -quot[qes_pkg::CW-1:0] : quot[qes_pkg::CW-1:0];
  endfunction

  function automatic roots_t predict_roots(input logic [qes_pkg::CW-1:0] a,
                                           input logic [qes_pkg::CW-1:0] b,
                                           input logic [qes_pkg::CW-1:0] c,
                                           input logic [qes_pkg::TW-1:0] tol);
    roots_t               r;
    logic signed [63:0]   a64, b64, c64, root_s;
    logic [63:0]          ma, mb, mc, tol64, root, trial;
    logic [127:0]         bb, ac4, disc;
    logic                 ovf;
    a64   = {{32{a[qes_pkg::CW-1]}}, a};
    b64   = {{32{b[qes_pkg::CW-1]}}, b};
    c64   = {{32{c[qes_pkg::CW-1]}}, c};
    ma    = (a64 < 0) ? -a64 : a64;
    mb    = (b64 < 0) ? -b64 : b64;
    mc    = (c64 < 0) ? -c64 : c64;
    tol64 = {48'd0, tol};
    ovf   = 1'b0;
    r.cnt = qes_pkg::CNT_NONE;
    r.lo  = '0;
    r.hi  = '0;
    if (ma <= tol64) begin
      if (mb <= tol64) begin
        r.cnt = (mc <= tol64) ? qes_pkg::CNT_INF : qes_pkg::CNT_NONE;
      end else begin
        r.lo  = scaled_quotient(-c64, mb, b64 < 0, ovf);
        r.hi  = r.lo;
        r.cnt = qes_pkg::CNT_ONE;
      end
    end else begin
      bb  = {64'd0, mb} * {64'd0, mb};
      ac4 = ({64'd0, ma} * {64'd0, mc}) << 2;
      if ((a64 < 0) != (c64 < 0) || ac4 <= bb) begin
        disc = ((a64 < 0) != (c64 < 0)) ? bb + ac4 : bb - ac4;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
          trial = root | (64'd1 << i);
          if ({64'd0, trial} * {64'd0, trial} <= disc) root = trial;
        end
        root_s = root;
        r.lo   = scaled_quotient(-b64 - root_s, ma << 1, a64 < 0, ovf);
        r.hi   = scaled_quotient(-b64 + root_s, ma << 1, a64 < 0, ovf);
        r.cnt  = qes_pkg::CNT_TWO;
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [qes_pkg::CW-1:0] got,
                                 input logic [qes_pkg::CW-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    roots_t want;
    if (!rst_n) begin
      tolerance = '0;
      expected_roots.delete();
    end else begin
      if (cfg_valid && cfg_ready) tolerance = cfg_data;
      if (in_valid && in_ready)
        expected_roots.push_back(predict_roots(in_coeff_a, in_coeff_b, in_coeff_c,
                                               tolerance));
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected result transfer", out_root_low, '0);
        end else begin
          want = expected_roots.pop_front();
          if (out_root_count != want.cnt)
            report_mismatch("root_count", {{(qes_pkg::CW-2){1'b0}}, out_root_count},
                            {{(qes_pkg::CW-2){1'b0}}, want.cnt});
          if (out_root_low != want.lo) report_mismatch("root_low", out_root_low, want.lo);
          if (out_root_high != want.hi) report_mismatch("root_high", out_root_high, want.hi);
          if (out_overflow != want.ovf)
            report_mismatch("overflow", {{(qes_pkg::CW-1){1'b0}}, out_overflow},
                            {{(qes_pkg::CW-1){1'b0}}, want.ovf});
        end
      end
    end
    roots_pending <= expected_roots.size();
    error_count   <= errors;
  end

endmodule

### test/quadratic_equation_solver_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadratic equation solver testbench
// Drives directed and random equations under several zero tolerances with
// random idling on both channels and one long result stall; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module quadratic_equation_solver_top_test;

  localparam int IDLE_LIMIT = 2000;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [qes_pkg::TW-1:0] cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [qes_pkg::CW-1:0] in_coeff_a;
  logic [qes_pkg::CW-1:0] in_coeff_b;
  logic [qes_pkg::CW-1:0] in_coeff_c;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_root_count;
  logic [qes_pkg::CW-1:0] out_root_low;
  logic [qes_pkg::CW-1:0] out_root_high;
  logic                   out_overflow;
  int                     roots_pending;
  int                     error_count;
  int                     idle_cycles;
  int                     results_seen;

  quadratic_equation_solver_top u_dut (.*);

  quadratic_equation_solver_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_equation(input logic [qes_pkg::CW-1:0] a,
                               input logic [qes_pkg::CW-1:0] b,
                               input logic [qes_pkg::CW-1:0] c);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coeff_a <= a;
    in_coeff_b <= b;
    in_coeff_c <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Waits for all results of the phase, then writes the tolerance.
  task automatic set_tolerance(input logic [qes_pkg::TW-1:0] tol);
    in_valid <= 1'b0;
    // Wait for a clock edge first so the pending count includes the last transfer.
    @(posedge clk);
    while (roots_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tol;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [qes_pkg::CW-1:0] random_coeff();
    logic [qes_pkg::CW-1:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h000f_ffff);
      2: v = -$urandom_range(0, 32'h000f_ffff);
      3: v = $urandom_range(0, 32'h0001_0000) - 32'h8000;
      default: v = ($urandom_range(0, 16) - 8) << 16;
    endcase
    return v;
  endfunction

  task automatic send_random(input int count);
    logic [qes_pkg::CW-1:0] a;
    logic [qes_pkg::CW-1:0] k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        // Perfect square: a*(x - k)^2 with small integers gives a double root.
        a = ($urandom_range(1, 4)) << 16;
        k = $urandom_range(0, 8) - 4;
        send_equation(a, -(a * 2 * k), (a * k) * k);
      end else begin
        send_equation(random_coeff(), random_coeff(), random_coeff());
      end
    end
  endtask

  // Receiver: random stall per result, one long hold to fill the pipeline.
  initial begin
    int stall;
    out_ready    = 1'b0;
    results_seen = 0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = (results_seen == 120) ? 400 :
              ($urandom_range(0, 2) == 0 ? $urandom_range(1, 5) : 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  initial begin
    int tol_draw;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_coeff_a  = '0;
    in_coeff_b  = '0;
    in_coeff_c  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_tolerance(16'd0);
    // Linear cases: all zero, contradiction, plain root, overflowing root.
    send_equation(32'd0, 32'd0, 32'd0);
    send_equation(32'd0, 32'd0, 32'd1);
    send_equation(32'd0, 32'h0002_0000, 32'hfffc_0000);
    send_equation(32'd0, 32'd1, 32'h7fff_ffff);
    send_equation(32'd0, 32'h8000_0000, 32'h8000_0000);
    // Two roots, double root, negative discriminant.
    send_equation(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
    send_equation(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_equation(32'h0001_0000, 32'd0, 32'h0001_0000);
    send_equation(32'hffff_0000, 32'd0, 32'hffff_0000);
    // Extremes of the fields and saturating roots.
    send_equation(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_equation(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_equation(32'd1, 32'h7fff_ffff, 32'd0);
    send_equation(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_equation(32'h8000_0000, 32'd0, 32'd0);

    set_tolerance(16'hffff);
    send_equation(32'h0000_ffff, 32'hffff_0001, 32'h0000_ffff);
    send_equation(32'h0001_0000, 32'h0000_ffff, 32'h0001_0000);
    send_equation(32'hffff_0001, 32'h0001_0000, 32'h0002_0000);
    send_equation(32'h0000_ffff, 32'hffff_0000, 32'h0001_0000);
    send_random(60);

    set_tolerance(16'd0);
    send_random(160);

    tol_draw = $urandom_range(1, 16'hfffe);
    set_tolerance(tol_draw[qes_pkg::TW-1:0]);
    send_random(100);

    set_tolerance(16'h0100);
    send_random(80);

    in_valid <= 1'b0;
    @(posedge clk);
    while (roots_pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
